// File: sv/qts_pkg.sv
package qts_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   localparam logic [1:0] KIND_TOKEN_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TOKEN_END   = 2'd1;
   localparam logic [1:0] KIND_END_OF_LINE = 2'd2;
   localparam logic [1:0] KIND_END_OF_TEXT = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [7:0]         token_byte;
      logic [15:0]        line_number;
      logic [15:0]        column_number;
      logic signed [31:0] decimal_value;
      logic               decimal_valid;
      logic signed [31:0] hex_value;
      logic               hex_valid;
      logic               last_of_run;
   } rsp_payload_type;

endpackage

// File: sv/quoted_token_scanner.sv
// Latency: a result is offered in the cycle after its byte is taken.
// Throughput: one byte per cycle unless the result side stalls; a byte that causes two
// results (token end then end of line or end of text) holds the request side until its
// first result leaves a two-entry result buffer that drains one transfer per cycle.
// Reset: synchronous; clears the token state, sets line and column to 1 and
// empties the result buffer.
module quoted_token_scanner #(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qts_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qts_pkg::rsp_payload_type rsp_payload
);

   // Phases of the two number readers, following scanf conversion rules.
   typedef enum logic [2:0] {
      DEC_START, DEC_PLUS, DEC_MINUS, DEC_DIG_POS, DEC_DIG_NEG,
      DEC_FAIL, DEC_STOP_POS, DEC_STOP_NEG
   } dec_phase_type;

   typedef enum logic [3:0] {
      HEX_START, HEX_PLUS, HEX_MINUS, HEX_ZERO_POS, HEX_ZERO_NEG,
      HEX_X_POS, HEX_X_NEG, HEX_DIG_POS, HEX_DIG_NEG, HEX_FAIL,
      HEX_STOP_POS, HEX_STOP_NEG
   } hex_phase_type;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Token and position state.
   logic                     token_open_ff, token_open_in;
   logic                     token_empty_ff, token_empty_in;
   logic                     quoting_ff, quoting_in;
   logic                     quote_pending_ff, quote_pending_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] column_ff, column_in;
   logic [31:0]              dec_acc_ff, dec_acc_in;
   dec_phase_type            dec_phase_ff, dec_phase_in;
   logic [31:0]              hex_acc_ff, hex_acc_in;
   hex_phase_type            hex_phase_ff, hex_phase_in;

   // Result buffer: slot 0 is the head that the result port shows.
   qts_pkg::rsp_payload_type slot0_ff, slot0_in;
   qts_pkg::rsp_payload_type slot1_ff, slot1_in;
   logic [1:0]               count_ff, count_in;

   // Results of the current byte.
   qts_pkg::rsp_payload_type res0, res1;
   logic [1:0]               res_count;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [15:0]              line_out;
   logic [15:0]              column_out;
   logic [31:0]              line_wide;
   logic [31:0]              column_wide;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == qts_pkg::CHAR_SPACE) || (c == qts_pkg::CHAR_TAB) ||
             (c == qts_pkg::CHAR_CR) || (c == qts_pkg::CHAR_LF) ||
             (c == qts_pkg::CHAR_VT) || (c == qts_pkg::CHAR_FF);
   endfunction

   // Bit 4 flags a hexadecimal digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= qts_pkg::CHAR_ZERO && c <= qts_pkg::CHAR_NINE) begin
         d = c - qts_pkg::CHAR_ZERO;
         return {1'b1, d[3:0]};
      end
      if (c >= qts_pkg::CHAR_LOW_A && c <= qts_pkg::CHAR_LOW_F) begin
         d = c - qts_pkg::CHAR_LOW_A + 8'd10;
         return {1'b1, d[3:0]};
      end
      if (c >= qts_pkg::CHAR_UP_A && c <= qts_pkg::CHAR_UP_F) begin
         d = c - qts_pkg::CHAR_UP_A + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic qts_pkg::rsp_payload_type make_event(input logic [1:0] kind,
                                                           input logic [7:0] byte_val,
                                                           input logic [15:0] line_val,
                                                           input logic [15:0] column_val);
      qts_pkg::rsp_payload_type r;
      r = '0;
      r.event_kind    = kind;
      r.token_byte    = byte_val;
      r.line_number   = line_val;
      r.column_number = column_val;
      return r;
   endfunction

   // Token end: the sign is applied only now, from the phase the reader stopped in.
   function automatic qts_pkg::rsp_payload_type make_token_end(input dec_phase_type dp,
                                                               input logic [31:0] dacc,
                                                               input hex_phase_type hp,
                                                               input logic [31:0] hacc,
                                                               input logic [15:0] line_val,
                                                               input logic [15:0] column_val);
      qts_pkg::rsp_payload_type r;
      logic dv, dn, hv, hn;
      r  = make_event(qts_pkg::KIND_TOKEN_END, 8'd0, line_val, column_val);
      dv = (dp == DEC_DIG_POS) || (dp == DEC_DIG_NEG) ||
           (dp == DEC_STOP_POS) || (dp == DEC_STOP_NEG);
      dn = (dp == DEC_DIG_NEG) || (dp == DEC_STOP_NEG);
      hv = (hp == HEX_ZERO_POS) || (hp == HEX_ZERO_NEG) || (hp == HEX_X_POS) ||
           (hp == HEX_X_NEG) || (hp == HEX_DIG_POS) || (hp == HEX_DIG_NEG) ||
           (hp == HEX_STOP_POS) || (hp == HEX_STOP_NEG);
      hn = (hp == HEX_ZERO_NEG) || (hp == HEX_X_NEG) || (hp == HEX_DIG_NEG) ||
           (hp == HEX_STOP_NEG);
      r.decimal_valid = dv;
      r.hex_valid     = hv;
      r.decimal_value = dv ? (dn ? 32'd0 - dacc : dacc) : 32'd0;
      r.hex_value     = hv ? (hn ? 32'd0 - hacc : hacc) : 32'd0;
      return r;
   endfunction

   // The buffer takes a byte only when it will be empty at this edge, so both
   // results of a byte always fit.
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot0_ff;
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign req_stall   = !((count_ff == 2'd0) || ((count_ff == 2'd1) && !rsp_stall));
   assign req_accept  = req_valid && !req_stall;

   assign line_wide   = 32'(line_ff);
   assign column_wide = 32'(column_ff);
   assign line_out    = line_wide[15:0];
   assign column_out  = column_wide[15:0];

   // Next token state and the results of the byte at the request port.
   always_comb begin
      logic [7:0] c;
      logic       t_empty, t_quoting, t_pending, add;
      logic [31:0] t_dacc, t_hacc;
      dec_phase_type t_dph;
      hex_phase_type t_hph;
      logic       dig;
      logic [3:0] dval;
      logic [4:0] hd;

      c         = req_payload.text_byte;
      dig       = (c >= qts_pkg::CHAR_ZERO) && (c <= qts_pkg::CHAR_NINE);
      dval      = c[3:0];
      hd        = hex_digit(c);
      add       = 1'b0;
      t_empty   = token_empty_ff;
      t_quoting = quoting_ff;
      t_pending = quote_pending_ff;
      t_dacc    = dec_acc_ff;
      t_hacc    = hex_acc_ff;
      t_dph     = dec_phase_ff;
      t_hph     = hex_phase_ff;

      token_open_in    = token_open_ff;
      token_empty_in   = token_empty_ff;
      quoting_in       = quoting_ff;
      quote_pending_in = quote_pending_ff;
      line_in          = line_ff;
      column_in        = column_ff;
      dec_acc_in       = dec_acc_ff;
      dec_phase_in     = dec_phase_ff;
      hex_acc_in       = hex_acc_ff;
      hex_phase_in     = hex_phase_ff;
      res0             = '0;
      res1             = '0;
      res_count        = 2'd0;

      if (req_payload.end_of_text) begin
         // An open token ends first; then everything returns to its reset values.
         if (token_open_ff) begin
            res0 = make_token_end(dec_phase_ff, dec_acc_ff, hex_phase_ff, hex_acc_ff,
                                  line_out, column_out);
            res1 = make_event(qts_pkg::KIND_END_OF_TEXT, 8'd0, line_out, column_out);
            res1.last_of_run = 1'b1;
            res_count = 2'd2;
         end else begin
            res0 = make_event(qts_pkg::KIND_END_OF_TEXT, 8'd0, line_out, column_out);
            res0.last_of_run = 1'b1;
            res_count = 2'd1;
         end
         token_open_in    = 1'b0;
         token_empty_in   = 1'b1;
         quoting_in       = 1'b0;
         quote_pending_in = 1'b0;
         line_in          = POS_ONE;
         column_in        = POS_ONE;
         dec_acc_in       = 32'd0;
         dec_phase_in     = DEC_START;
         hex_acc_in       = 32'd0;
         hex_phase_in     = HEX_START;
      end else if (!token_open_ff && ((c == qts_pkg::CHAR_SPACE) ||
                   (c == qts_pkg::CHAR_TAB) || (c == qts_pkg::CHAR_CR))) begin
         // Separator between tokens: only the column moves.
         column_in = sat_inc(column_ff);
      end else if (!token_open_ff && (c == qts_pkg::CHAR_LF)) begin
         res0 = make_event(qts_pkg::KIND_END_OF_LINE, 8'd0, line_out, column_out);
         res0.last_of_run = 1'b1;
         res_count = 2'd1;
         line_in   = sat_inc(line_ff);
         column_in = POS_ONE;
      end else begin
         // A byte that opens a token starts from a clean token state.
         if (!token_open_ff) begin
            t_empty   = 1'b1;
            t_quoting = 1'b0;
            t_pending = 1'b0;
            t_dacc    = 32'd0;
            t_hacc    = 32'd0;
            t_dph     = DEC_START;
            t_hph     = HEX_START;
         end
         token_open_in = 1'b1;

         // A lone quote inside quoting followed by anything else closes quoting.
         if (t_quoting && t_pending && (c != qts_pkg::CHAR_QUOTE)) begin
            t_quoting = 1'b0;
            t_pending = 1'b0;
         end

         if (((c == qts_pkg::CHAR_SPACE) && !t_quoting) || (c == qts_pkg::CHAR_TAB) ||
             (c == qts_pkg::CHAR_CR) || (c == qts_pkg::CHAR_LF)) begin
            res0 = make_token_end(t_dph, t_dacc, t_hph, t_hacc, line_out, column_out);
            token_open_in    = 1'b0;
            token_empty_in   = 1'b1;
            quoting_in       = 1'b0;
            quote_pending_in = 1'b0;
            dec_acc_in       = 32'd0;
            dec_phase_in     = DEC_START;
            hex_acc_in       = 32'd0;
            hex_phase_in     = HEX_START;
            if (c == qts_pkg::CHAR_LF) begin
               res1 = make_event(qts_pkg::KIND_END_OF_LINE, 8'd0, line_out, column_out);
               res1.last_of_run = 1'b1;
               res_count = 2'd2;
               line_in   = sat_inc(line_ff);
               column_in = POS_ONE;
            end else begin
               res0.last_of_run = 1'b1;
               res_count = 2'd1;
               column_in = sat_inc(column_ff);
            end
         end else begin
            if (c == qts_pkg::CHAR_QUOTE) begin
               if (!t_quoting && t_empty) begin
                  t_quoting = 1'b1;
               end else if (t_pending) begin
                  add       = 1'b1;
                  t_pending = 1'b0;
               end else begin
                  t_pending = 1'b1;
               end
            end else begin
               t_pending = 1'b0;
               add       = 1'b1;
            end

            if (add) begin
               t_empty = 1'b0;

               unique case (t_dph)
                  DEC_START: begin
                     if (!is_space(c)) begin
                        if (c == qts_pkg::CHAR_PLUS) begin
                           t_dph = DEC_PLUS;
                        end else if (c == qts_pkg::CHAR_MINUS) begin
                           t_dph = DEC_MINUS;
                        end else if (dig) begin
                           t_dacc = 32'(dval);
                           t_dph  = DEC_DIG_POS;
                        end else begin
                           t_dph = DEC_FAIL;
                        end
                     end
                  end
                  DEC_PLUS, DEC_MINUS: begin
                     if (dig) begin
                        t_dacc = 32'(dval);
                        t_dph  = (t_dph == DEC_PLUS) ? DEC_DIG_POS : DEC_DIG_NEG;
                     end else begin
                        t_dph = DEC_FAIL;
                     end
                  end
                  DEC_DIG_POS, DEC_DIG_NEG: begin
                     if (dig) begin
                        t_dacc = (t_dacc << 3) + (t_dacc << 1) + 32'(dval);
                     end else begin
                        t_dph = (t_dph == DEC_DIG_POS) ? DEC_STOP_POS : DEC_STOP_NEG;
                     end
                  end
                  default: begin
                  end
               endcase

               unique case (t_hph)
                  HEX_START: begin
                     if (!is_space(c)) begin
                        if (c == qts_pkg::CHAR_PLUS) begin
                           t_hph = HEX_PLUS;
                        end else if (c == qts_pkg::CHAR_MINUS) begin
                           t_hph = HEX_MINUS;
                        end else if (c == qts_pkg::CHAR_ZERO) begin
                           t_hacc = 32'd0;
                           t_hph  = HEX_ZERO_POS;
                        end else if (hd[4]) begin
                           t_hacc = 32'(hd[3:0]);
                           t_hph  = HEX_DIG_POS;
                        end else begin
                           t_hph = HEX_FAIL;
                        end
                     end
                  end
                  HEX_PLUS, HEX_MINUS: begin
                     if (c == qts_pkg::CHAR_ZERO) begin
                        t_hacc = 32'd0;
                        t_hph  = (t_hph == HEX_PLUS) ? HEX_ZERO_POS : HEX_ZERO_NEG;
                     end else if (hd[4]) begin
                        t_hacc = 32'(hd[3:0]);
                        t_hph  = (t_hph == HEX_PLUS) ? HEX_DIG_POS : HEX_DIG_NEG;
                     end else begin
                        t_hph = HEX_FAIL;
                     end
                  end
                  HEX_ZERO_POS, HEX_ZERO_NEG: begin
                     if ((c == qts_pkg::CHAR_LOW_X) || (c == qts_pkg::CHAR_UP_X)) begin
                        t_hph = (t_hph == HEX_ZERO_POS) ? HEX_X_POS : HEX_X_NEG;
                     end else if (hd[4]) begin
                        t_hacc = {t_hacc[27:0], hd[3:0]};
                        t_hph  = (t_hph == HEX_ZERO_POS) ? HEX_DIG_POS : HEX_DIG_NEG;
                     end else begin
                        t_hph = (t_hph == HEX_ZERO_POS) ? HEX_STOP_POS : HEX_STOP_NEG;
                     end
                  end
                  HEX_X_POS, HEX_X_NEG: begin
                     if (hd[4]) begin
                        t_hacc = {t_hacc[27:0], hd[3:0]};
                        t_hph  = (t_hph == HEX_X_POS) ? HEX_DIG_POS : HEX_DIG_NEG;
                     end else begin
                        t_hph = (t_hph == HEX_X_POS) ? HEX_STOP_POS : HEX_STOP_NEG;
                     end
                  end
                  HEX_DIG_POS, HEX_DIG_NEG: begin
                     if (hd[4]) begin
                        t_hacc = {t_hacc[27:0], hd[3:0]};
                     end else begin
                        t_hph = (t_hph == HEX_DIG_POS) ? HEX_STOP_POS : HEX_STOP_NEG;
                     end
                  end
                  default: begin
                  end
               endcase

               res0 = make_event(qts_pkg::KIND_TOKEN_BYTE, c, line_out, column_out);
               res0.last_of_run = 1'b1;
               res_count = 2'd1;
            end

            token_empty_in   = t_empty;
            quoting_in       = t_quoting;
            quote_pending_in = t_pending;
            dec_acc_in       = t_dacc;
            dec_phase_in     = t_dph;
            hex_acc_in       = t_hacc;
            hex_phase_in     = t_hph;
            column_in        = sat_inc(column_ff);
         end
      end
   end

   // Result buffer: a taken byte loads its results, otherwise a transfer shifts.
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (req_accept) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = res_count;
      end else if (rsp_accept) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         token_open_ff    <= 1'b0;
         token_empty_ff   <= 1'b1;
         quoting_ff       <= 1'b0;
         quote_pending_ff <= 1'b0;
         line_ff          <= POS_ONE;
         column_ff        <= POS_ONE;
         dec_acc_ff       <= 32'd0;
         dec_phase_ff     <= DEC_START;
         hex_acc_ff       <= 32'd0;
         hex_phase_ff     <= HEX_START;
         count_ff         <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            token_open_ff    <= token_open_in;
            token_empty_ff   <= token_empty_in;
            quoting_ff       <= quoting_in;
            quote_pending_ff <= quote_pending_in;
            line_ff          <= line_in;
            column_ff        <= column_in;
            dec_acc_ff       <= dec_acc_in;
            dec_phase_ff     <= dec_phase_in;
            hex_acc_ff       <= hex_acc_in;
            hex_phase_ff     <= hex_phase_in;
         end
      end
   end

   // The buffer never holds more than the two results of one byte.
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("result buffer over two entries");

   // A byte with two results fills the buffer at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (res_count == 2'd2) |=> (count_ff == 2'd2))
      else $error("second result of a byte lost");

   // End of text returns the scanner to its reset position.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.end_of_text |=>
         !token_open_ff && (line_ff == POS_ONE) && (column_ff == POS_ONE))
      else $error("end of text did not clear the scanner");

   // Only a token end carries number readings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind != qts_pkg::KIND_TOKEN_END) |->
         !rsp_payload.decimal_valid && !rsp_payload.hex_valid &&
         (rsp_payload.decimal_value == 32'sd0) && (rsp_payload.hex_value == 32'sd0))
      else $error("number reading on a non token-end result");

   // A token byte is never a tab, line feed or carriage return, which end a token even inside quoting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind == qts_pkg::KIND_TOKEN_BYTE) |->
         (rsp_payload.token_byte != qts_pkg::CHAR_TAB) &&
         (rsp_payload.token_byte != qts_pkg::CHAR_LF) &&
         (rsp_payload.token_byte != qts_pkg::CHAR_CR))
      else $error("separator reported as token byte");

endmodule

// File: bench/quoted_token_scanner_tb.sv
`timescale 1ns / 1ps

module quoted_token_scanner_tb;

   // The line and column counters of the block are this wide and saturate at the top.
   localparam int POSITION_BITS = 16;
   localparam int unsigned POSITION_MAX = (1 << POSITION_BITS) - 1;

   // The run is ended by force after this many cycles.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // Random tokens to send after the directed pass, counted in bytes.
   localparam int unsigned RANDOM_ITEMS = 700;
   // The last bytes of the random part go out with no idling on either side.
   localparam int unsigned QUIET_TAIL = 120;

   // Progress of the scanf-style decimal reading of the current token.
   typedef enum logic [2:0] {
      DEC_START,
      DEC_SIGN,
      DEC_DIGITS,
      DEC_FAIL,
      DEC_STOPPED
   } dec_phase_type;

   // Progress of the scanf-style hexadecimal reading, with the optional 0x prefix.
   typedef enum logic [2:0] {
      HEX_START,
      HEX_SIGN,
      HEX_ZERO,
      HEX_PREFIX,
      HEX_DIGITS,
      HEX_FAIL,
      HEX_STOPPED
   } hex_phase_type;

   // The scoreboard keeps its own copy of the scanner state. Each accepted byte is run
   // through it, and the results that the byte causes are queued in order. Each result
   // transfer from the block is then checked against the oldest queued result.
   class token_scoreboard;
      bit                        token_open;
      bit                        token_empty;
      bit                        quoting;
      bit                        quote_pending;
      int unsigned               line_count;
      int unsigned               column_count;
      logic [31:0]               dec_acc;
      bit                        dec_negative;
      dec_phase_type             dec_phase;
      logic [31:0]               hex_acc;
      bit                        hex_negative;
      hex_phase_type             hex_phase;
      qts_pkg::rsp_payload_type  expected_q[$];
      qts_pkg::rsp_payload_type  run_q[$];
      int unsigned               mismatches;
      int unsigned               results_seen;
      int unsigned               tokens_seen;

      function new();
         restart();
      endfunction

      function void clear_token();
         token_open    = 1'b0;
         token_empty   = 1'b1;
         quoting       = 1'b0;
         quote_pending = 1'b0;
         dec_acc       = '0;
         dec_negative  = 1'b0;
         dec_phase     = DEC_START;
         hex_acc       = '0;
         hex_negative  = 1'b0;
         hex_phase     = HEX_START;
      endfunction

      function void restart();
         clear_token();
         line_count   = 1;
         column_count = 1;
      endfunction

      function int unsigned bump(int unsigned v);
         return (v >= POSITION_MAX) ? POSITION_MAX : v + 1;
      endfunction

      // The white space that scanf skips before a number.
      function bit is_blank(logic [7:0] c);
         return c == qts_pkg::CHAR_SPACE || c == qts_pkg::CHAR_TAB ||
                c == qts_pkg::CHAR_CR || c == qts_pkg::CHAR_LF ||
                c == qts_pkg::CHAR_VT || c == qts_pkg::CHAR_FF;
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= qts_pkg::CHAR_ZERO && c <= qts_pkg::CHAR_NINE)
            return int'(c - qts_pkg::CHAR_ZERO);
         if (c >= qts_pkg::CHAR_LOW_A && c <= qts_pkg::CHAR_LOW_F)
            return int'(c - qts_pkg::CHAR_LOW_A) + 10;
         if (c >= qts_pkg::CHAR_UP_A && c <= qts_pkg::CHAR_UP_F)
            return int'(c - qts_pkg::CHAR_UP_A) + 10;
         return -1;
      endfunction

      function void feed_decimal(logic [7:0] c);
         bit          digit;
         logic [31:0] d;
         digit = c >= qts_pkg::CHAR_ZERO && c <= qts_pkg::CHAR_NINE;
         d = 32'(c) - 32'(qts_pkg::CHAR_ZERO);
         case (dec_phase)
            DEC_START: begin
               if (!is_blank(c)) begin
                  if (c == qts_pkg::CHAR_PLUS) begin
                     dec_phase = DEC_SIGN;
                  end else if (c == qts_pkg::CHAR_MINUS) begin
                     dec_phase    = DEC_SIGN;
                     dec_negative = 1'b1;
                  end else if (digit) begin
                     dec_acc   = d;
                     dec_phase = DEC_DIGITS;
                  end else begin
                     dec_phase = DEC_FAIL;
                  end
               end
            end
            DEC_SIGN: begin
               if (digit) begin
                  dec_acc   = d;
                  dec_phase = DEC_DIGITS;
               end else begin
                  dec_phase = DEC_FAIL;
               end
            end
            DEC_DIGITS: begin
               if (digit) dec_acc = dec_acc * 32'd10 + d;
               else dec_phase = DEC_STOPPED;
            end
            default: ;
         endcase
      endfunction

      function void feed_hex(logic [7:0] c);
         int h;
         h = hex_digit(c);
         case (hex_phase)
            HEX_START: begin
               if (!is_blank(c)) begin
                  if (c == qts_pkg::CHAR_PLUS) begin
                     hex_phase = HEX_SIGN;
                  end else if (c == qts_pkg::CHAR_MINUS) begin
                     hex_phase    = HEX_SIGN;
                     hex_negative = 1'b1;
                  end else if (c == qts_pkg::CHAR_ZERO) begin
                     hex_acc   = '0;
                     hex_phase = HEX_ZERO;
                  end else if (h >= 0) begin
                     hex_acc   = 32'(h);
                     hex_phase = HEX_DIGITS;
                  end else begin
                     hex_phase = HEX_FAIL;
                  end
               end
            end
            HEX_SIGN: begin
               if (c == qts_pkg::CHAR_ZERO) begin
                  hex_acc   = '0;
                  hex_phase = HEX_ZERO;
               end else if (h >= 0) begin
                  hex_acc   = 32'(h);
                  hex_phase = HEX_DIGITS;
               end else begin
                  hex_phase = HEX_FAIL;
               end
            end
            HEX_ZERO: begin
               if (c == qts_pkg::CHAR_LOW_X || c == qts_pkg::CHAR_UP_X) begin
                  hex_phase = HEX_PREFIX;
               end else if (h >= 0) begin
                  hex_acc   = hex_acc * 32'd16 + 32'(h);
                  hex_phase = HEX_DIGITS;
               end else begin
                  hex_phase = HEX_STOPPED;
               end
            end
            HEX_PREFIX, HEX_DIGITS: begin
               if (h >= 0) begin
                  hex_acc   = hex_acc * 32'd16 + 32'(h);
                  hex_phase = HEX_DIGITS;
               end else begin
                  hex_phase = HEX_STOPPED;
               end
            end
            default: ;
         endcase
      endfunction

      // A result with both number readings at zero; the caller fills in the rest.
      function qts_pkg::rsp_payload_type mark(logic [1:0] kind, logic [7:0] b,
                                              int unsigned col);
         qts_pkg::rsp_payload_type r;
         r = '0;
         r.event_kind    = kind;
         r.token_byte    = b;
         r.line_number   = line_count[15:0];
         r.column_number = col[15:0];
         return r;
      endfunction

      function qts_pkg::rsp_payload_type token_summary(int unsigned col);
         qts_pkg::rsp_payload_type r;
         bit                       dv;
         bit                       hv;
         r  = mark(qts_pkg::KIND_TOKEN_END, 8'h00, col);
         dv = dec_phase inside {DEC_DIGITS, DEC_STOPPED};
         hv = hex_phase inside {HEX_ZERO, HEX_PREFIX, HEX_DIGITS, HEX_STOPPED};
         r.decimal_valid = dv;
         r.hex_valid     = hv;
         if (dv) r.decimal_value = dec_negative ? 32'd0 - dec_acc : dec_acc;
         if (hv) r.hex_value = hex_negative ? 32'd0 - hex_acc : hex_acc;
         tokens_seen++;
         return r;
      endfunction

      // Works out the results of one byte into run_q and moves the scanner state on.
      function void predict(qts_pkg::req_payload_type p);
         logic [7:0]  c;
         int unsigned col;
         bit          add;
         c   = p.text_byte;
         col = column_count;
         if (p.end_of_text) begin
            if (token_open) run_q.push_back(token_summary(col));
            run_q.push_back(mark(qts_pkg::KIND_END_OF_TEXT, 8'h00, col));
            restart();
            return;
         end
         if (!token_open) begin
            if (c == qts_pkg::CHAR_SPACE || c == qts_pkg::CHAR_TAB ||
                c == qts_pkg::CHAR_CR) begin
               column_count = bump(column_count);
               return;
            end
            if (c == qts_pkg::CHAR_LF) begin
               run_q.push_back(mark(qts_pkg::KIND_END_OF_LINE, 8'h00, col));
               line_count   = bump(line_count);
               column_count = 1;
               return;
            end
            clear_token();
            token_open = 1'b1;
         end
         // A lone quote inside quoting, followed by anything but a quote, closes quoting.
         if (quoting && quote_pending && c != qts_pkg::CHAR_QUOTE) begin
            quoting       = 1'b0;
            quote_pending = 1'b0;
         end
         if ((c == qts_pkg::CHAR_SPACE && !quoting) || c == qts_pkg::CHAR_TAB ||
             c == qts_pkg::CHAR_CR || c == qts_pkg::CHAR_LF) begin
            run_q.push_back(token_summary(col));
            clear_token();
            if (c == qts_pkg::CHAR_LF) begin
               run_q.push_back(mark(qts_pkg::KIND_END_OF_LINE, 8'h00, col));
               line_count   = bump(line_count);
               column_count = 1;
            end else begin
               column_count = bump(column_count);
            end
            return;
         end
         add = 1'b0;
         if (c == qts_pkg::CHAR_QUOTE) begin
            if (!quoting && token_empty) begin
               quoting = 1'b1;
            end else if (quote_pending) begin
               add           = 1'b1;
               quote_pending = 1'b0;
            end else begin
               quote_pending = 1'b1;
            end
         end else begin
            quote_pending = 1'b0;
            add           = 1'b1;
         end
         if (add) begin
            token_empty = 1'b0;
            feed_decimal(c);
            feed_hex(c);
            run_q.push_back(mark(qts_pkg::KIND_TOKEN_BYTE, c, col));
         end
         column_count = bump(column_count);
      endfunction

      function void note_input(qts_pkg::req_payload_type p);
         qts_pkg::rsp_payload_type last;
         run_q.delete();
         predict(p);
         if (run_q.size() != 0) begin
            last = run_q[run_q.size() - 1];
            last.last_of_run = 1'b1;
            run_q[run_q.size() - 1] = last;
         end
         foreach (run_q[i]) expected_q.push_back(run_q[i]);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Prints one line per mismatch. Past the first fifty only the count goes on, so
      // that a badly broken block cannot flood the log.
      task report(string msg);
         if (mismatches < 50) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d, %s is %0h, expected %0h",
                             results_seen, name, got, want));
      endtask

      task check_result(qts_pkg::rsp_payload_type got);
         qts_pkg::rsp_payload_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d of kind %0d arrived with nothing expected",
                             results_seen, got.event_kind));
            return;
         end
         want = expected_q.pop_front();
         check_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
         check_field("token_byte", 32'(got.token_byte), 32'(want.token_byte));
         check_field("line_number", 32'(got.line_number), 32'(want.line_number));
         check_field("column_number", 32'(got.column_number), 32'(want.column_number));
         check_field("decimal_value", got.decimal_value, want.decimal_value);
         check_field("decimal_valid", 32'(got.decimal_valid), 32'(want.decimal_valid));
         check_field("hex_value", got.hex_value, want.hex_value);
         check_field("hex_valid", 32'(got.hex_valid), 32'(want.hex_valid));
         check_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   qts_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   qts_pkg::rsp_payload_type rsp_payload;

   token_scoreboard sb = new();

   // Idling switches for the two sides, and the bookkeeping of the run.
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int unsigned stall_left = 0;
   int unsigned items_sent = 0;
   int unsigned cycles = 0;

   quoted_token_scanner #(
      .POSITION_BITS(POSITION_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // Watchdog. A run that hangs on a handshake ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The result side stalls in bursts of random length. A burst that has started
   // always runs to its end, even when idling is switched off in the meantime.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (receiver_idles && !reset && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 9) - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // All signals here change only through nonblocking assignments, so at a rising edge
   // this block still sees the values from before the edge: a result transfer happens
   // exactly when valid was high and stall was low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
   end

   // Offers one byte, after an optional gap, and holds it until the block takes it.
   // The valid line stays high from one transfer to the next when there is no gap.
   task automatic send_item(input logic [7:0] b, input logic eot);
      int unsigned gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{text_byte: b, end_of_text: eot};
      do @(posedge clock); while (req_stall);
      sb.note_input(req_payload);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // Withdraws the request and holds the sender back until every expected result has
   // come out of the block.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] random_hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) return qts_pkg::CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? qts_pkg::CHAR_LOW_A : qts_pkg::CHAR_UP_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] random_printable();
      return 8'($urandom_range(33, 126));
   endfunction

   // One token of random shape and content, followed by one or more separators or, now and then,
   // by the end of the text. Most tokens are well-formed numbers or quoted strings so
   // that the number readers get past their first states; the rest is noise.
   task automatic send_random_token();
      int unsigned shape;
      int unsigned n;
      int unsigned sep;
      int unsigned pick;
      shape = $urandom_range(0, 9);
      case (shape)
         0, 1, 2: begin
            pick = $urandom_range(0, 3);
            if (pick == 0) send_item(qts_pkg::CHAR_PLUS, 1'b0);
            if (pick == 1) send_item(qts_pkg::CHAR_MINUS, 1'b0);
            if ($urandom_range(0, 7) == 0)
               send_item($urandom_range(0, 1) ? qts_pkg::CHAR_VT : qts_pkg::CHAR_FF, 1'b0);
            // Up to twelve digits, so that some values wrap past 32 bits.
            n = $urandom_range(1, 12);
            repeat (n) send_item(qts_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 3) == 0) send_item(random_printable(), 1'b0);
         end
         3, 4, 5: begin
            pick = $urandom_range(0, 3);
            if (pick == 0) send_item(qts_pkg::CHAR_PLUS, 1'b0);
            if (pick == 1) send_item(qts_pkg::CHAR_MINUS, 1'b0);
            pick = $urandom_range(0, 2);
            if (pick != 0) begin
               send_item(qts_pkg::CHAR_ZERO, 1'b0);
               send_item(pick == 1 ? qts_pkg::CHAR_LOW_X : qts_pkg::CHAR_UP_X, 1'b0);
            end
            // With a prefix the digits may be missing, which gives a bare 0x.
            n = $urandom_range(pick != 0 ? 0 : 1, 10);
            repeat (n) send_item(random_hex_char(), 1'b0);
            if ($urandom_range(0, 3) == 0) send_item(random_printable(), 1'b0);
         end
         6, 7: begin
            send_item(qts_pkg::CHAR_QUOTE, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) begin
               pick = $urandom_range(0, 5);
               if (pick == 0) begin
                  send_item(qts_pkg::CHAR_SPACE, 1'b0);
               end else if (pick == 1) begin
                  send_item(qts_pkg::CHAR_QUOTE, 1'b0);
                  send_item(qts_pkg::CHAR_QUOTE, 1'b0);
               end else begin
                  send_item(random_printable(), 1'b0);
               end
            end
            if ($urandom_range(0, 3) != 0) send_item(qts_pkg::CHAR_QUOTE, 1'b0);
         end
         8: begin
            // Quotes alone make an empty token, or add quote characters to one.
            n = $urandom_range(1, 4);
            repeat (n) send_item(qts_pkg::CHAR_QUOTE, 1'b0);
         end
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
         end
      endcase
      if ($urandom_range(0, 29) == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 1;
         repeat (n) begin
            sep = $urandom_range(0, 15);
            if (sep <= 7) send_item(qts_pkg::CHAR_SPACE, 1'b0);
            else if (sep <= 10) send_item(qts_pkg::CHAR_TAB, 1'b0);
            else if (sep == 11) send_item(qts_pkg::CHAR_CR, 1'b0);
            else send_item(qts_pkg::CHAR_LF, 1'b0);
         end
      end
   endtask

   initial begin
      int unsigned target;
      bit          paused;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A line feed and the other separators outside a token, a negative
      // number ended by a line feed, a quoted token with a kept space, a doubled quote
      // and a lone quote that closes quoting, a hex token with a 0X prefix and a doubled
      // quote outside quoting, the extreme byte values, and a token still open at the
      // end of the text, whose byte is ignored.
      send_text("\n \t\r-12\n");
      send_text("\"a \"\"\" ");
      send_text("0Xf\"\"\t");
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      wait_for_drain();

      // Random part. Halfway through, the sender waits until the block has gone idle.
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      target = items_sent + RANDOM_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
         if (items_sent + QUIET_TAIL >= target) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if (!paused && items_sent + RANDOM_ITEMS / 2 >= target) begin
            wait_for_drain();
            paused = 1'b1;
         end
         send_random_token();
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);

      // Everything has been sent. Let the last results come out, then keep the result
      // checker running so that any stray result would still be caught.
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes and checked %0d results covering %0d completed tokens.",
               items_sent, sb.results_seen, sb.tokens_seen);
      $display("Covered directed cases and random numbers, quoted strings, quote runs");
      $display("and noise, with and without idling on both sides.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
